// File: design/ert_pkg.sv
// shared types and constants of the expiring relay table
package ert_pkg;

  localparam int KEY_W      = 256;
  localparam int WORD_W     = 64;
  localparam int HANDLE_W   = 32;
  localparam int NOW_W      = 63;
  localparam int EXPIRY_W   = 64;
  localparam int LIFETIME_W = 40;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 7;

  localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 40'd900000000;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_EXPIRE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // accepted request item as held by the datapath
  typedef struct packed {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] tx_handle;
    logic [NOW_W-1:0]    now_us;
  } item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic clear;
    logic mark_present;
    logic mark_found;
    logic mark_full;
    logic insert;
    logic pop;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_done;
    logic full;
    logic empty;
    logic head_expired;
    logic out_free;
  } stat_t;

endpackage

// File: design/ert_ifs.sv
// request and response channel interfaces
interface ert_req_if import ert_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [WORD_W-1:0]   key_word0;
  logic [WORD_W-1:0]   key_word1;
  logic [WORD_W-1:0]   key_word2;
  logic [WORD_W-1:0]   key_word3;
  logic [HANDLE_W-1:0] tx_handle;
  logic [NOW_W-1:0]    now_us;

  modport source (
    output valid, op, key_word0, key_word1, key_word2, key_word3, tx_handle, now_us,
    input  ready
  );
  modport sink (
    input  valid, op, key_word0, key_word1, key_word2, key_word3, tx_handle, now_us,
    output ready
  );
endinterface

interface ert_rsp_if import ert_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 found;
  logic [HANDLE_W-1:0]  found_handle;
  logic [CNT_OUT_W-1:0] expired_count;
  logic [CNT_OUT_W-1:0] entries_held;

  modport source (
    output valid, status, found, found_handle, expired_count, entries_held,
    input  ready
  );
  modport sink (
    input  valid, status, found, found_handle, expired_count, entries_held,
    output ready
  );
endinterface

// File: design/ert_ram.sv
// generic single write port ram with registered read
module ert_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/ert_ctrl.sv
// sequencing state machine of the expiring relay table
module ert_ctrl import ert_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_op,
  output logic       req_ready,
  input  stat_t      st,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXP_RD,
    S_EXP_CMP,
    S_DONE
  } state_t;

  state_t state, state_next;
  op_t    op_q;
  logic   accept;

  assign accept = req_valid && req_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          unique case (op_t'(req_op))
            OP_INSERT, OP_LOOKUP: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
            OP_EXPIRE: state_next = S_EXP_RD;
            OP_CLEAR: begin
              cmd.clear  = 1'b1;
              state_next = S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        priority if (st.hit) begin
          cmd.mark_present = (op_q == OP_INSERT);
          cmd.mark_found   = (op_q == OP_LOOKUP);
          state_next       = S_DONE;
        end else if (st.scan_done) begin
          if (op_q == OP_INSERT) begin
            cmd.mark_full = st.full;
            cmd.insert    = !st.full;
          end
          state_next = S_DONE;
        end else begin
          // keep walking the held keys
          state_next = S_SCAN;
        end
      end
      S_EXP_RD: begin
        state_next = st.empty ? S_DONE : S_EXP_CMP;
      end
      S_EXP_CMP: begin
        if (st.head_expired) begin
          cmd.pop    = 1'b1;
          state_next = S_EXP_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
      op_q      <= OP_INSERT;
    end else begin
      state     <= state_next;
      req_ready <= (state_next == S_IDLE);
      if (accept) begin
        op_q <= op_t'(req_op);
      end
    end
  end

  // a pop is only ever ordered on a non-empty table
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !st.empty) else $error("pop on empty table");

  // ready only in idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> state == S_IDLE) else $error("ready outside idle");

  // after a result is loaded into the output register the block is ready for the next item
  a_emit_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> req_ready) else $error("not ready after emit");

endmodule

// File: design/ert_datapath.sv
// storage, ring pointers, scan and result registers of the expiring relay table
module ert_datapath import ert_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [LIFETIME_W-1:0] cfg_wr_data,
  input  item_t                 item,
  input  cmd_t                  cmd,
  output stat_t                 st,
  ert_rsp_if.source             rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [LIFETIME_W-1:0] lifetime;
  item_t                 item_q;
  logic [IW-1:0]         head, tail, scan_ptr;
  logic [CW-1:0]         count, scan_left, res_removed;
  logic                  rd_pend;
  logic [STATUS_W-1:0]   res_status;
  logic                  res_found;
  logic [HANDLE_W-1:0]   res_handle;

  logic [KEY_W-1:0]    key_rdata;
  logic [HANDLE_W-1:0] handle_rdata;
  logic [EXPIRY_W-1:0] exp_rdata;
  logic [EXPIRY_W-1:0] expiry_new;
  logic [EXPIRY_W-1:0] now_ext;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] s);
    return (s == IW'(CAPACITY - 1)) ? '0 : s + 1'b1;
  endfunction

  assign now_ext    = {1'b0, item_q.now_us};
  assign expiry_new = now_ext + EXPIRY_W'(lifetime);

  ert_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (tail),
    .wdata (item_q.key),
    .raddr (scan_ptr),
    .rdata (key_rdata)
  );

  ert_ram #(.WIDTH(HANDLE_W), .DEPTH(CAPACITY)) u_handle_ram (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (tail),
    .wdata (item_q.tx_handle),
    .raddr (scan_ptr),
    .rdata (handle_rdata)
  );

  // expiry port always reads the oldest slot
  ert_ram #(.WIDTH(EXPIRY_W), .DEPTH(CAPACITY)) u_expiry_ram (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (tail),
    .wdata (expiry_new),
    .raddr (head),
    .rdata (exp_rdata)
  );

  assign st.hit          = rd_pend && (key_rdata == item_q.key);
  assign st.scan_done    = !rd_pend && (scan_left == '0);
  assign st.full         = (count == CW'(CAPACITY));
  assign st.empty        = (count == '0);
  assign st.head_expired = (exp_rdata < now_ext);
  assign st.out_free     = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime  <= LIFETIME_RESET;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rd_pend   <= 1'b0;
      scan_left <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lifetime <= cfg_wr_data;
      end
      if (cmd.load) begin
        item_q      <= item;
        res_status  <= ST_DONE;
        res_found   <= 1'b0;
        res_handle  <= '0;
        // clear comes with the load and reports what it removes
        res_removed <= cmd.clear ? count : '0;
      end
      if (cmd.scan_start) begin
        scan_ptr  <= head;
        scan_left <= count;
        rd_pend   <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (scan_left != '0) begin
          scan_ptr  <= next_slot(scan_ptr);
          scan_left <= scan_left - 1'b1;
          rd_pend   <= 1'b1;
        end else begin
          rd_pend <= 1'b0;
        end
      end
      if (cmd.clear) begin
        head  <= '0;
        tail  <= '0;
        count <= '0;
      end
      if (cmd.mark_present) begin
        res_status <= ST_PRESENT;
      end
      if (cmd.mark_found) begin
        res_found  <= 1'b1;
        res_handle <= handle_rdata;
      end
      if (cmd.mark_full) begin
        res_status <= ST_FULL;
      end
      if (cmd.insert) begin
        tail  <= next_slot(tail);
        count <= count + 1'b1;
      end
      if (cmd.pop) begin
        head        <= next_slot(head);
        count       <= count - 1'b1;
        res_removed <= res_removed + 1'b1;
      end
      if (cmd.emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status        <= res_status;
      rsp.found         <= res_found;
      rsp.found_handle  <= res_handle;
      rsp.expired_count <= CNT_OUT_W'(res_removed);
      rsp.entries_held  <= CNT_OUT_W'(count);
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("entry count above capacity");

  a_ring_ends: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CW'(CAPACITY)) |-> head == tail)
    else $error("ring pointers disagree with count");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !st.full) else $error("insert into full table");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free) else $error("result overwritten");

endmodule

// File: design/expiring_relay_table_core.sv
// top level of the expiring relay table
//
// request channel req: one item per operation (insert, lookup, expire, clear)
// carrying a 256-bit key in four words, a handle and the current time
// response channel rsp: exactly one result item per request item, in order
// config port: cfg_wr_en / cfg_wr_data write the entry lifetime in microseconds
// entries sit in a ring in insertion order, oldest at the head
// insert and lookup compare the held keys one per cycle through the key ram,
// stopping early on a match
// expire reads the oldest expiry and pops it while below the current time,
// stopping at an unexpired entry or an empty table; clear empties the table
// one item is worked at a time; the next is taken once the result sits in
// the output register, even while the receiver has not yet taken it
// a stalled receiver holds the result register and the block waits before
// loading the following result
// reset empties the table and sets the lifetime to 900000000; the rams are
// not swept, since only held slots are ever read
module expiring_relay_table_core import ert_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [LIFETIME_W-1:0] cfg_wr_data,
  ert_req_if.sink               req,
  ert_rsp_if.source             rsp
);

  cmd_t  cmd;
  stat_t st;
  item_t item;

  // pack the request fields, key word 0 in the low bits
  assign item.op        = op_t'(req.op);
  assign item.key       = {req.key_word3, req.key_word2, req.key_word1, req.key_word0};
  assign item.tx_handle = req.tx_handle;
  assign item.now_us    = req.now_us;

  ert_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  ert_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .cmd         (cmd),
    .st          (st),
    .rsp         (rsp)
  );

endmodule

// File: dv/expiring_relay_table_checker.sv
// checker for the expiring relay table: shadow table, queue of replies due, field compare
`timescale 1ns / 1ps
module expiring_relay_table_checker import ert_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [LIFETIME_W-1:0] cfg_wr_data,
  ert_req_if                    req,
  ert_rsp_if                    rsp,
  output int                    mismatches,
  output int                    pending,
  output int                    items_seen,
  output int                    hits_seen,
  output int                    dups_seen,
  output int                    drops_seen,
  output int                    aged_seen
);

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 found;
    logic [HANDLE_W-1:0]  found_handle;
    logic [CNT_OUT_W-1:0] expired_count;
    logic [CNT_OUT_W-1:0] entries_held;
  } reply_t;

  // shadow copy of the ring
  logic [KEY_W-1:0]      held_key    [CAPACITY];
  logic [HANDLE_W-1:0]   held_handle [CAPACITY];
  logic [EXPIRY_W-1:0]   held_expiry [CAPACITY];
  int                    oldest    = 0;
  int                    next_free = 0;
  int                    held_n    = 0;
  logic [LIFETIME_W-1:0] lifetime  = LIFETIME_RESET;

  reply_t replies_due [$];
  int     err_n  = 0;
  int     acc_n  = 0;
  int     hit_n  = 0;
  int     dup_n  = 0;
  int     drop_n = 0;
  int     aged_n = 0;

  function automatic int ring_next(input int s);
    return (s + 1 >= CAPACITY) ? 0 : s + 1;
  endfunction

  function automatic int find_held(input logic [KEY_W-1:0] key);
    int s;
    s = oldest;
    for (int i = 0; i < held_n; i++) begin
      if (held_key[s] == key) return s;
      s = ring_next(s);
    end
    return -1;
  endfunction

  // applies one request to the shadow table and returns the reply it must cause
  task automatic table_step(input op_t op, input logic [KEY_W-1:0] key,
                            input logic [HANDLE_W-1:0] handle,
                            input logic [NOW_W-1:0] now, output reply_t r);
    int slot;
    r = '0;
    slot = find_held(key);
    case (op)
      OP_INSERT: begin
        if (slot >= 0) begin
          r.status = ST_PRESENT;
        end else if (held_n >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          held_key[next_free]    = key;
          held_handle[next_free] = handle;
          held_expiry[next_free] = EXPIRY_W'(now) + EXPIRY_W'(lifetime);
          next_free = ring_next(next_free);
          held_n++;
        end
      end
      OP_LOOKUP: begin
        if (slot >= 0) begin
          r.found        = 1'b1;
          r.found_handle = held_handle[slot];
        end
      end
      OP_EXPIRE: begin
        while (held_n > 0 && held_expiry[oldest] < EXPIRY_W'(now)) begin
          oldest = ring_next(oldest);
          held_n--;
          r.expired_count = r.expired_count + 1'b1;
        end
      end
      default: begin
        r.expired_count = CNT_OUT_W'(held_n);
        oldest    = 0;
        next_free = 0;
        held_n    = 0;
      end
    endcase
    r.entries_held = CNT_OUT_W'(held_n);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      oldest    = 0;
      next_free = 0;
      held_n    = 0;
      lifetime  = LIFETIME_RESET;
    end else begin
      if (cfg_wr_en) lifetime = cfg_wr_data;
      // result side first: a reply never leaves in the cycle its request enters
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          err_n++;
          $error("result item with no request outstanding");
        end else begin
          want = replies_due[0];
          replies_due.delete(0);
          if (rsp.status !== want.status) begin
            err_n++;
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
          end
          if (rsp.found !== want.found) begin
            err_n++;
            $error("found: expected %0d, actual %0d", want.found, rsp.found);
          end
          if (rsp.found_handle !== want.found_handle) begin
            err_n++;
            $error("found_handle: expected %0h, actual %0h", want.found_handle,
                   rsp.found_handle);
          end
          if (rsp.expired_count !== want.expired_count) begin
            err_n++;
            $error("expired_count: expected %0d, actual %0d", want.expired_count,
                   rsp.expired_count);
          end
          if (rsp.entries_held !== want.entries_held) begin
            err_n++;
            $error("entries_held: expected %0d, actual %0d", want.entries_held,
                   rsp.entries_held);
          end
        end
      end
      if (req.valid && req.ready) begin
        table_step(op_t'(req.op), {req.key_word3, req.key_word2, req.key_word1, req.key_word0},
                   req.tx_handle, req.now_us, want);
        replies_due = {replies_due, want};
        acc_n++;
        if (want.status == ST_PRESENT) dup_n++;
        if (want.status == ST_FULL) drop_n++;
        if (want.found) hit_n++;
        aged_n += want.expired_count;
      end
    end
    mismatches <= err_n;
    pending    <= replies_due.size();
    items_seen <= acc_n;
    hits_seen  <= hit_n;
    dups_seen  <= dup_n;
    drops_seen <= drop_n;
    aged_seen  <= aged_n;
  end

endmodule

// File: dv/expiring_relay_table_core_test.sv
// testbench top for the expiring relay table: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module expiring_relay_table_core_test;
  import ert_pkg::*;

  localparam int CAPACITY      = 64;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SEGMENT_ITEMS = 180;
  localparam int FILL_ITEMS    = 70;
  localparam int POOL_N        = 16;

  localparam logic [NOW_W-1:0]      NOW_MAX      = '1;
  localparam logic [LIFETIME_W-1:0] LIFETIME_MAX = '1;
  localparam logic [HANDLE_W-1:0]   HANDLE_MAX   = '1;
  // two keys that differ only in the top word, plus the all-zero key
  localparam logic [KEY_W-1:0]      KEY_A        = '1;
  localparam logic [KEY_W-1:0]      KEY_B        = {64'd0, {192{1'b1}}};
  localparam logic [KEY_W-1:0]      KEY_Z        = '0;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_wr_en   = 1'b0;
  logic [LIFETIME_W-1:0] cfg_wr_data = '0;

  ert_req_if req_ch ();
  ert_rsp_if rsp_ch ();

  int mismatches, pending, items_seen, hits_seen, dups_seen, drops_seen, aged_seen;

  int cycles      = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // long receiver hold-off: the stimulus bumps hold_req, the receiver loop counts it out
  int hold_req    = 0;
  int hold_ack    = 0;
  int hold_left   = 0;

  logic [NOW_W-1:0] sim_now;
  logic [KEY_W-1:0] key_pool [POOL_N];

  expiring_relay_table_core #(.CAPACITY(CAPACITY)) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  expiring_relay_table_checker #(.CAPACITY(CAPACITY)) chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .pending     (pending),
    .items_seen  (items_seen),
    .hits_seen   (hits_seen),
    .dups_seen   (dups_seen),
    .drops_seen  (drops_seen),
    .aged_seen   (aged_seen)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL expiring_relay_table_core");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_ack     <= hold_req;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [NOW_W-1:0] random_now();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[NOW_W-1:0];
  endfunction

  // offers one item and returns at the edge where it is taken; valid stays high
  // so that a following item can go out back to back
  task automatic send_item(input op_t op, input logic [KEY_W-1:0] key,
                           input logic [HANDLE_W-1:0] handle, input logic [NOW_W-1:0] now);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.key_word0 <= key[63:0];
    req_ch.key_word1 <= key[127:64];
    req_ch.key_word2 <= key[191:128];
    req_ch.key_word3 <= key[255:192];
    req_ch.tx_handle <= handle;
    req_ch.now_us    <= now;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // sender pauses until every reply is back, then idles on before returning
  task automatic wait_table_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // register write, only with the table idle
  task automatic set_lifetime(input logic [LIFETIME_W-1:0] value);
    wait_table_idle();
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // one random item: mostly pool keys so inserts collide and lookups hit,
  // time creeping forward with the odd jump back and the odd wild value
  task automatic send_random();
    int               r;
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [NOW_W-1:0] now;
    r  = $urandom_range(99);
    op = (r < 45) ? OP_INSERT : (r < 75) ? OP_LOOKUP : (r < 96) ? OP_EXPIRE : OP_CLEAR;
    key = ($urandom_range(99) < 70) ? key_pool[$urandom_range(POOL_N-1)] : random_key();
    r = $urandom_range(99);
    if (r < 4) now = random_now();
    else if (r < 8 && sim_now > 64) now = sim_now - $urandom_range(64);
    else now = sim_now;
    sim_now = sim_now + $urandom_range(6);
    send_item(op, key, $urandom, now);
  endtask

  task automatic run_segment(input int tx_pct, input int rx_pct,
                             input logic [LIFETIME_W-1:0] life);
    set_lifetime(life);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    for (int i = 0; i < SEGMENT_ITEMS; i++) begin
      // one mid-segment pause with everything drained
      if (i == SEGMENT_ITEMS / 2) wait_table_idle();
      send_random();
    end
  endtask

  initial begin
    logic [KEY_W-1:0] first_key;

    req_ch.valid     = 1'b0;
    req_ch.op        = OP_INSERT;
    req_ch.key_word0 = '0;
    req_ch.key_word1 = '0;
    req_ch.key_word2 = '0;
    req_ch.key_word3 = '0;
    req_ch.tx_handle = '0;
    req_ch.now_us    = '0;
    sim_now          = 1000;

    // key pool: the upper half repeats the lower half with one bit flipped,
    // walking the flip over all four key words
    for (int j = 0; j < POOL_N / 2; j++) key_pool[j] = random_key();
    for (int j = POOL_N / 2; j < POOL_N; j++)
      key_pool[j] = key_pool[j - POOL_N / 2] ^
                    (KEY_W'(1) << (64 * (j % 4) + $urandom_range(63)));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part, first idling mode, reset lifetime
    tx_idle_pct = 24;
    rx_idle_pct <= 45;
    send_item(OP_LOOKUP, KEY_Z, '0, '0);           // lookup on empty table
    send_item(OP_EXPIRE, KEY_Z, '0, NOW_MAX);      // expire on empty table
    send_item(OP_CLEAR, KEY_Z, '0, '0);            // clear on empty table
    send_item(OP_INSERT, KEY_A, '0, '0);           // expiry lands on 900000000
    send_item(OP_INSERT, KEY_A, HANDLE_MAX, 5);    // duplicate, expiry untouched
    send_item(OP_LOOKUP, KEY_A, '0, '0);
    send_item(OP_LOOKUP, KEY_B, '0, '0);           // differs only in top word
    send_item(OP_INSERT, KEY_B, HANDLE_MAX, NOW_MAX);
    send_item(OP_INSERT, KEY_Z, 32'h1234, 10);
    send_item(OP_LOOKUP, KEY_B, '0, '0);
    send_item(OP_EXPIRE, KEY_Z, '0, 900000000);    // equal is not expired
    send_item(OP_EXPIRE, KEY_Z, '0, 900000001);    // pops A, B blocks the rest
    send_item(OP_EXPIRE, KEY_Z, '0, '0);           // time going backwards
    send_item(OP_LOOKUP, KEY_A, '0, '0);
    send_item(OP_CLEAR, KEY_Z, '0, '0);

    // zero lifetime: gone as soon as time passes the insert time
    set_lifetime('0);
    send_item(OP_INSERT, KEY_A, 55, 100);
    send_item(OP_EXPIRE, KEY_Z, '0, 100);
    send_item(OP_EXPIRE, KEY_Z, '0, 101);

    // smallest nonzero lifetime
    set_lifetime(1);
    send_item(OP_INSERT, KEY_B, 77, 200);
    send_item(OP_EXPIRE, KEY_Z, '0, 201);
    send_item(OP_EXPIRE, KEY_Z, '0, 202);

    // largest lifetime on top of the largest time: widest expiry sum
    set_lifetime(LIFETIME_MAX);
    send_item(OP_INSERT, KEY_A, HANDLE_MAX, NOW_MAX);
    send_item(OP_LOOKUP, KEY_A, '0, '0);
    send_item(OP_CLEAR, KEY_Z, '0, '0);

    // random, sender idle percentage 24 and receiver idle percentage 45
    run_segment(24, 45, LIFETIME_W'($urandom_range(400, 30)));

    // fill the table while the receiver holds off: the block backs up and
    // stalls its input, then the table runs full and a duplicate hits it
    set_lifetime(LIFETIME_MAX);
    send_item(OP_CLEAR, KEY_Z, '0, sim_now);
    hold_req <= hold_req + 1;
    first_key = random_key();
    send_item(OP_INSERT, first_key, $urandom, sim_now);
    for (int i = 0; i < FILL_ITEMS; i++) send_item(OP_INSERT, random_key(), $urandom, sim_now);
    send_item(OP_INSERT, first_key, $urandom, sim_now);
    send_item(OP_LOOKUP, first_key, '0, sim_now);
    send_item(OP_EXPIRE, KEY_Z, '0, sim_now);

    // random, roles swapped
    run_segment(45, 24, LIFETIME_W'($urandom_range(3000, 500)));
    // random, no idling on either side
    run_segment(0, 0, LIFETIME_W'($urandom_range(200, 10)));

    wait_table_idle();
    repeat (40) @(posedge clk);
    $display("covered %0d request items: %0d lookup hits, %0d duplicate inserts, %0d drops",
             items_seen, hits_seen, dups_seen, drops_seen);
    $display("%0d entries aged out or cleared, lifetimes zero, one, reset, max and random",
             aged_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS expiring_relay_table_core");
    end else begin
      $display("FAIL expiring_relay_table_core");
    end
    $finish;
  end

endmodule
